// ----- src/mld_pkg.sv -----
// Package with shared types, constants and functions of the frame deframer.
`timescale 1ns / 1ps
package mld_pkg;

  // Frame counter width (wraps at this width)
  localparam int COUNT_BITS = 32;

  // Result burst geometry
  localparam int MAX_RES = 6;
  localparam int RES_IDX_W = 3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_MPEG1 = 3'd1;
  localparam logic [2:0] ST_NOT_L1    = 3'd2;
  localparam logic [2:0] ST_NOT_384K  = 3'd3;
  localparam logic [2:0] ST_MONO      = 3'd4;
  localparam logic [2:0] ST_BAD_RATE  = 3'd5;
  localparam logic [2:0] ST_RATE_MISM = 3'd6;
  localparam logic [2:0] ST_TRUNC     = 3'd7;

  // Sample rate codes from the header
  localparam logic [1:0] RATE_44K = 2'd0;
  localparam logic [1:0] RATE_48K = 2'd1;
  localparam logic [1:0] RATE_32K = 2'd2;
  localparam logic [1:0] RATE_BAD = 2'd3;

  // Frame sizes in bytes, header included
  localparam logic [9:0] SIZE_44K     = 10'd416;
  localparam logic [9:0] SIZE_44K_PAD = 10'd420;
  localparam logic [9:0] SIZE_48K     = 10'd384;
  localparam logic [9:0] SIZE_32K     = 10'd576;
  localparam logic [9:0] HDR_BYTES    = 10'd4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_FRAME,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_data;
    logic        frame_end;
    logic [2:0]  status;
    logic [31:0] frames_done;
    logic        last;
  } out_t;

  // One step's results, handed from the core to the output queue
  typedef struct packed {
    logic [RES_IDX_W-1:0]      cnt;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic                      is_data;
    logic                      fend;
    logic [2:0]                status;
    logic [31:0]               frames_done;
  } burst_t;

  // Rate id byte of the MPP rate header
  function automatic logic [7:0] rate_id(input logic [1:0] r);
    logic [7:0] v;
    case (r)
      RATE_44K: v = 8'd44;
      RATE_48K: v = 8'd48;
      RATE_32K: v = 8'd32;
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/mld_core.sv -----
// Sync hunt, header check and frame tracking; builds one result burst per word.
`timescale 1ns / 1ps
module mld_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             accept,
  input  mld_pkg::in_t     in_word,
  output mld_pkg::burst_t  burst
);

  mld_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [9:0]  left_r, left_nxt;
  logic [1:0]  locked_r, locked_nxt;
  logic        started_r, started_nxt;
  logic        pad_r, pad_nxt;
  logic [mld_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        mpp_r;

  // Decode
  logic [31:0] win_sh;
  logic [7:0]  b0, b1, b2, b3;
  logic [1:0]  rate;
  logic [9:0]  size;
  logic [9:0]  left_dec;
  logic        win_full, sync_hit;
  logic [2:0]  hdr_err;
  logic        need_rate_hdr;

  always_comb begin
    win_sh   = {window_r[23:0], in_word.in_byte};
    b0       = win_sh[31:24];
    b1       = win_sh[23:16];
    b2       = win_sh[15:8];
    b3       = win_sh[7:0];
    win_full = (fill_r >= 3'd3);
    sync_hit = win_full && (b0 == 8'hFF) && ((b1 & 8'hF0) == 8'hF0);
    rate     = (b2 & 8'h0C) >> 2 == 8'd0 ? 2'd0 : b2[3:2];
    left_dec = left_r - 10'd1;
    case (rate)
      mld_pkg::RATE_44K: size = b2[1] ? mld_pkg::SIZE_44K_PAD : mld_pkg::SIZE_44K;
      mld_pkg::RATE_48K: size = mld_pkg::SIZE_48K;
      default:           size = mld_pkg::SIZE_32K;
    endcase
    need_rate_hdr = mpp_r && !started_r;
    // Header checks in priority order
    if ((b1 & 8'h08) != 8'h08) begin
      hdr_err = mld_pkg::ST_NOT_MPEG1;
    end else if ((b1 & 8'h06) != 8'h06) begin
      hdr_err = mld_pkg::ST_NOT_L1;
    end else if ((b2 & 8'hF0) != 8'hC0) begin
      hdr_err = mld_pkg::ST_NOT_384K;
    end else if ((b3 & 8'hC0) == 8'hC0) begin
      hdr_err = mld_pkg::ST_MONO;
    end else if (rate == mld_pkg::RATE_BAD) begin
      hdr_err = mld_pkg::ST_BAD_RATE;
    end else if (mpp_r && started_r && (rate != locked_r)) begin
      hdr_err = mld_pkg::ST_RATE_MISM;
    end else begin
      hdr_err = mld_pkg::ST_OK;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      mld_pkg::PH_HUNT: begin
        if (in_word.kind) begin
          phase_nxt = mld_pkg::PH_HUNT;
        end else if (sync_hit) begin
          phase_nxt = (hdr_err == mld_pkg::ST_OK) ? mld_pkg::PH_FRAME : mld_pkg::PH_ERROR;
        end
      end
      mld_pkg::PH_FRAME: begin
        if (in_word.kind || (left_dec == 10'd0)) begin
          phase_nxt = mld_pkg::PH_HUNT;
        end
      end
      mld_pkg::PH_ERROR: phase_nxt = mld_pkg::PH_ERROR;
      default:           phase_nxt = mld_pkg::PH_HUNT;
    endcase
  end

  // State updates and result burst
  always_comb begin
    window_nxt  = window_r;
    fill_nxt    = fill_r;
    left_nxt    = left_r;
    locked_nxt  = locked_r;
    started_nxt = started_r;
    pad_nxt     = pad_r;
    count_nxt   = count_r;
    err_nxt     = err_r;

    burst.cnt     = '0;
    burst.bytes   = '0;
    burst.is_data = 1'b0;
    burst.fend    = 1'b0;
    burst.status  = mld_pkg::ST_OK;

    case (phase_r)
      mld_pkg::PH_ERROR: begin
        if (in_word.kind) begin
          burst.cnt    = 3'd1;
          burst.status = err_r;
        end
      end
      mld_pkg::PH_FRAME: begin
        if (in_word.kind) begin
          burst.cnt    = 3'd1;
          burst.status = mld_pkg::ST_TRUNC;
          window_nxt   = '0;
          fill_nxt     = '0;
          left_nxt     = '0;
          pad_nxt      = 1'b0;
        end else begin
          left_nxt       = left_dec;
          burst.is_data  = 1'b1;
          burst.bytes[0] = in_word.in_byte;
          if (left_dec != 10'd0) begin
            burst.cnt = 3'd1;
          end else begin
            count_nxt  = count_r + 1'b1;
            burst.fend = 1'b1;
            burst.cnt  = pad_r ? 3'd5 : 3'd1;
            pad_nxt    = 1'b0;
            window_nxt = '0;
            fill_nxt   = '0;
          end
        end
      end
      default: begin
        if (in_word.kind) begin
          // end of stream while hunting: drop the partial window
          burst.cnt  = 3'd1;
          window_nxt = '0;
          fill_nxt   = '0;
          left_nxt   = '0;
          pad_nxt    = 1'b0;
        end else if (!sync_hit) begin
          window_nxt = win_sh;
          fill_nxt   = win_full ? 3'd4 : fill_r + 3'd1;
        end else if (hdr_err != mld_pkg::ST_OK) begin
          burst.cnt    = 3'd1;
          burst.status = hdr_err;
          err_nxt      = hdr_err;
          window_nxt   = '0;
          fill_nxt     = '0;
        end else begin
          burst.is_data = 1'b1;
          if (need_rate_hdr) begin
            burst.cnt   = 3'd6;
            burst.bytes = {b3, b2, b1, b0, 8'd0, mld_pkg::rate_id(rate)};
            started_nxt = 1'b1;
            locked_nxt  = rate;
          end else begin
            burst.cnt   = 3'd4;
            burst.bytes = {16'd0, b3, b2, b1, b0};
          end
          left_nxt   = size - mld_pkg::HDR_BYTES;
          pad_nxt    = mpp_r && (rate == mld_pkg::RATE_44K) && (size == mld_pkg::SIZE_44K);
          window_nxt = '0;
          fill_nxt   = '0;
        end
      end
    endcase
    burst.frames_done = 32'(count_nxt);
  end

  // Hold state; advance on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mld_pkg::PH_HUNT;
      window_r  <= '0;
      fill_r    <= '0;
      left_r    <= '0;
      locked_r  <= '0;
      started_r <= 1'b0;
      pad_r     <= 1'b0;
      count_r   <= '0;
      err_r     <= mld_pkg::ST_OK;
      mpp_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        mpp_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r   <= phase_nxt;
        window_r  <= window_nxt;
        fill_r    <= fill_nxt;
        left_r    <= left_nxt;
        locked_r  <= locked_nxt;
        started_r <= started_nxt;
        pad_r     <= pad_nxt;
        count_r   <= count_nxt;
        err_r     <= err_nxt;
      end
    end
  end

endmodule

// ----- src/mld_burst.sv -----
// Result register that holds one burst and hands it out one word per cycle while out_stall is low.
`timescale 1ns / 1ps
module mld_burst (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  mld_pkg::burst_t burst,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_stall,
  output mld_pkg::out_t   out_data
);

  logic [mld_pkg::RES_IDX_W-1:0]    cnt_r;
  logic [mld_pkg::RES_IDX_W-1:0]    idx_r;
  logic [mld_pkg::MAX_RES-1:0][7:0] bytes_r;
  logic                             is_data_r;
  logic                             fend_r;
  logic [2:0]                       status_r;
  logic [31:0]                      done_r;
  logic                             is_last;
  logic                             take;

  // Drive the word at the read index
  always_comb begin
    is_last   = (idx_r == cnt_r - 1'b1);
    out_valid = (cnt_r != '0);
    take      = out_valid && !out_stall;
    can_load  = !out_valid || (take && is_last);
    out_data.out_byte    = bytes_r[idx_r];
    out_data.is_data     = is_data_r;
    out_data.frame_end   = fend_r && is_last;
    out_data.status      = status_r;
    out_data.frames_done = done_r;
    out_data.last        = is_last;
  end

  // Load a new burst or advance through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
      idx_r <= '0;
    end else if (take) begin
      if (is_last) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r   <= burst.bytes;
      is_data_r <= burst.is_data;
      fend_r    <= burst.fend;
      status_r  <= burst.status;
      done_r    <= burst.frames_done;
    end
  end

endmodule

// ----- src/mpeg1_layer1_frame_deframer_top.sv -----
// Top level of the MPEG-1 Layer 1 frame deframer.
`timescale 1ns / 1ps
// Input channel (in_valid/in_stall/in_data) carries stream bytes or an
// end-of-stream marker; the result channel (out_valid/out_stall/out_data)
// carries emitted bytes and status words, each with a last flag.
// cfg_we/cfg_wdata write the MPP mode bit; write it only while idle.
// The first result of a word is on the output in the cycle after the word
// is accepted. A word yields 0 to 6 results, handed out one per cycle from
// the result register while out_stall is low; a new word is taken in the
// cycle the final result of the previous burst leaves, so frame body bytes
// flow at one per cycle while out_stall is low. A header gives 4 results (6
// with the rate header), the end of a padded frame 5, via the single read port.
// Words that produce no result (sync hunt, ignored bytes after an error)
// are taken every cycle while the result register is empty.
// A stall on the result channel holds the current result and stalls the
// input once the burst is pending. Reset (rst_n low, synchronous) empties
// the result register, clears the frame counter, rate lock and latched
// error, and returns to sync hunt with MPP mode off.
module mpeg1_layer1_frame_deframer_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  mld_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mld_pkg::out_t out_data
);

  mld_pkg::burst_t burst;
  logic            can_load;
  logic            accept;
  logic            load;

  // Accept a word whenever the result register can take its burst
  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;
  assign load     = accept && (burst.cnt != '0);

  mld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_word   (in_data),
    .burst     (burst)
  );

  mld_burst u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/mpeg1_layer1_frame_deframer_top_test.sv -----
// Self-checking testbench for the MPEG-1 Layer 1 frame deframer.
`timescale 1ns / 1ps
module mpeg1_layer1_frame_deframer_top_test;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic          cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  mld_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  mld_pkg::out_t out_data;

  mpeg1_layer1_frame_deframer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock, 8 ns period
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Shadow copy of the deframer state and its mode register
  logic            mode_mpp;
  mld_pkg::phase_t sh_phase;
  logic [31:0]     sh_window;
  int              sh_fill;
  logic [9:0]      sh_left;
  logic [1:0]      sh_lock;
  logic            sh_started;
  logic            sh_pad;
  logic [31:0]     sh_frames;
  logic [2:0]      sh_err;

  // Results of the word being predicted, then the queue of pending results
  mld_pkg::out_t   step_res [mld_pkg::MAX_RES];
  int              step_n;
  mld_pkg::out_t   pending_q [$];
  mld_pkg::out_t   want_res;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_req;
  int          hold_left;
  int          mismatch_count;
  int          missing_count;

  function automatic logic [9:0] frame_bytes(input logic [1:0] r, input logic padbit);
    logic [9:0] n;
    case (r)
      mld_pkg::RATE_44K: n = padbit ? mld_pkg::SIZE_44K_PAD : mld_pkg::SIZE_44K;
      mld_pkg::RATE_48K: n = mld_pkg::SIZE_48K;
      default:           n = mld_pkg::SIZE_32K;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] rate_tag_byte(input logic [1:0] r);
    logic [7:0] v;
    case (r)
      mld_pkg::RATE_44K: v = 8'd44;
      mld_pkg::RATE_48K: v = 8'd48;
      default:           v = 8'd32;
    endcase
    return v;
  endfunction

  // Pick a rate the block will accept in the current mode
  function automatic logic [1:0] allowed_rate();
    logic [1:0] r;
    if (mode_mpp && sh_started) begin
      r = sh_lock;
    end else begin
      r = 2'($urandom_range(0, 2));
    end
    return r;
  endfunction

  task automatic add_result(input logic [7:0] b, input logic dat, input logic fend,
                            input logic [2:0] st);
    step_res[step_n].out_byte    = b;
    step_res[step_n].is_data     = dat;
    step_res[step_n].frame_end   = fend;
    step_res[step_n].status      = st;
    step_res[step_n].frames_done = sh_frames;
    step_res[step_n].last        = 1'b0;
    step_n++;
  endtask

  task automatic clear_window();
    sh_window = '0;
    sh_fill   = 0;
  endtask

  task automatic shadow_reset();
    mode_mpp   = 1'b0;
    sh_phase   = mld_pkg::PH_HUNT;
    sh_window  = '0;
    sh_fill    = 0;
    sh_left    = '0;
    sh_lock    = mld_pkg::RATE_44K;
    sh_started = 1'b0;
    sh_pad     = 1'b0;
    sh_frames  = '0;
    sh_err     = mld_pkg::ST_OK;
  endtask

  // Advance the shadow state by one accepted word and queue its results
  task automatic predict_word(input mld_pkg::in_t w);
    logic [7:0] b0, b1, b2, b3;
    logic [1:0] r;
    logic [9:0] fsize;
    logic [2:0] code;
    step_n = 0;
    code   = mld_pkg::ST_OK;
    if (sh_phase == mld_pkg::PH_ERROR) begin
      // latched error: only end of stream reports, data is dropped
      if (w.kind) add_result(8'h00, 1'b0, 1'b0, sh_err);
    end else if (w.kind) begin
      add_result(8'h00, 1'b0, 1'b0,
                 (sh_phase == mld_pkg::PH_FRAME) ? mld_pkg::ST_TRUNC : mld_pkg::ST_OK);
      sh_phase = mld_pkg::PH_HUNT;
      clear_window();
      sh_left = '0;
      sh_pad  = 1'b0;
    end else if (sh_phase == mld_pkg::PH_FRAME) begin
      sh_left = sh_left - 10'd1;
      if (sh_left != 0) begin
        add_result(w.in_byte, 1'b1, 1'b0, mld_pkg::ST_OK);
      end else begin
        // final frame byte, with zero padding when due
        sh_frames = sh_frames + 32'd1;
        if (sh_pad) begin
          add_result(w.in_byte, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(8'h00, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(8'h00, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(8'h00, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(8'h00, 1'b1, 1'b1, mld_pkg::ST_OK);
        end else begin
          add_result(w.in_byte, 1'b1, 1'b1, mld_pkg::ST_OK);
        end
        sh_pad   = 1'b0;
        sh_phase = mld_pkg::PH_HUNT;
        clear_window();
      end
    end else begin
      // slide the sync window and check a candidate header
      sh_window = {sh_window[23:0], w.in_byte};
      if (sh_fill < 4) sh_fill++;
      {b0, b1, b2, b3} = sh_window;
      r = b2[3:2];
      if (sh_fill == 4 && b0 == 8'hFF && b1[7:4] == 4'hF) begin
        if (!b1[3]) code = mld_pkg::ST_NOT_MPEG1;
        else if (b1[2:1] != 2'b11) code = mld_pkg::ST_NOT_L1;
        else if (b2[7:4] != 4'hC) code = mld_pkg::ST_NOT_384K;
        else if (b3[7:6] == 2'b11) code = mld_pkg::ST_MONO;
        else if (r == mld_pkg::RATE_BAD) code = mld_pkg::ST_BAD_RATE;
        else if (mode_mpp && sh_started && r != sh_lock) code = mld_pkg::ST_RATE_MISM;
        if (code != mld_pkg::ST_OK) begin
          sh_phase = mld_pkg::PH_ERROR;
          sh_err   = code;
          clear_window();
          add_result(8'h00, 1'b0, 1'b0, code);
        end else begin
          if (mode_mpp && !sh_started) begin
            add_result(rate_tag_byte(r), 1'b1, 1'b0, mld_pkg::ST_OK);
            add_result(8'h00, 1'b1, 1'b0, mld_pkg::ST_OK);
            sh_started = 1'b1;
            sh_lock    = r;
          end
          add_result(b0, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(b1, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(b2, 1'b1, 1'b0, mld_pkg::ST_OK);
          add_result(b3, 1'b1, 1'b0, mld_pkg::ST_OK);
          fsize    = frame_bytes(r, b2[1]);
          sh_left  = fsize - mld_pkg::HDR_BYTES;
          sh_pad   = mode_mpp && r == mld_pkg::RATE_44K && fsize == mld_pkg::SIZE_44K;
          sh_phase = mld_pkg::PH_FRAME;
          clear_window();
        end
      end
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_q.push_back(step_res[i]);
  endtask

  // Offer one word, hold it until accepted, then predict its results
  task automatic send_word(input logic kind, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = {kind, b};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(in_data);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b);
  endtask

  task automatic send_eos();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_body(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Bytes that never form a sync word; now and then a lone 0xFF
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'hFF);
        send_byte(8'($urandom_range(0, 8'hEF)));
      end else begin
        send_byte(8'($urandom_range(0, 254)));
      end
    end
  endtask

  task automatic send_header(input logic [1:0] r, input logic padbit);
    logic prot;
    logic priv;
    logic [1:0] chmode;
    logic [5:0] tail;
    prot   = 1'($urandom_range(0, 1));
    priv   = 1'($urandom_range(0, 1));
    chmode = 2'($urandom_range(0, 2));
    tail   = 6'($urandom_range(0, 63));
    send_byte(8'hFF);
    send_byte({4'hF, 1'b1, 2'b11, prot});
    send_byte({4'hC, r, padbit, priv});
    send_byte({chmode, tail});
  endtask

  task automatic send_full_frame(input logic [1:0] r, input logic padbit);
    send_header(r, padbit);
    send_body(frame_bytes(r, padbit) - mld_pkg::HDR_BYTES);
  endtask

  // Drop valid and hold until every pending result has left the block
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    mode_mpp  = v;
  endtask

  // Sync hunting, dropped bytes, partial windows and truncation
  task automatic test_hunt_directed();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hA5);
    send_eos();
    send_byte(8'hFF);
    send_byte(8'h3A);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_eos();
    send_header(mld_pkg::RATE_48K, 1'b0);
    send_eos();
    send_header(mld_pkg::RATE_32K, 1'b1);
    send_body(5);
    send_eos();
    send_eos();
  endtask

  // Headers of every size, cut short, plain pass-through
  task automatic test_plain_frames();
    send_header(mld_pkg::RATE_48K, 1'b0);
    send_body(6);
    send_eos();
    send_noise(3);
    send_header(mld_pkg::RATE_32K, 1'($urandom_range(0, 1)));
    send_body(3);
    send_eos();
    send_header(mld_pkg::RATE_44K, 1'b0);
    send_eos();
    send_noise(2);
    send_header(mld_pkg::RATE_44K, 1'b1);
    send_body(2);
    send_eos();
  endtask

  // Container mode: rate header, rate lock and 44.1 kHz padding
  task automatic test_mpp_frames();
    write_mode(1'b1);
    send_full_frame(mld_pkg::RATE_44K, 1'b0);
    send_noise(4);
    send_header(mld_pkg::RATE_44K, 1'b1);
    send_body(6);
    send_eos();
    send_header(mld_pkg::RATE_44K, 1'b0);
    send_body(10);
    send_eos();
    send_eos();
  endtask

  // Headers cut short at random points, with noise and stray markers
  task automatic test_random_stream(input int count);
    int pick;
    logic [1:0] r;
    logic padbit;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_noise($urandom_range(1, 8));
      end else if (pick == 2) begin
        send_eos();
      end else begin
        r      = allowed_rate();
        padbit = 1'($urandom_range(0, 1));
        send_header(r, padbit);
        send_body($urandom_range(0, 8));
        send_eos();
      end
    end
  endtask

  // Hold the receiver off long enough to fill the block and stall the input
  task automatic test_backpressure();
    hold_req = 100;
    send_header(allowed_rate(), 1'b0);
    send_body(12);
    send_eos();
    drain_results();
    send_header(allowed_rate(), 1'b1);
    send_body(12);
    send_eos();
  endtask

  // One header error, then check that it stays latched
  task automatic test_latched_error();
    logic [2:0] code;
    logic [7:0] b1, b2, b3;
    logic [1:0] r;
    int nib;
    code = 3'($urandom_range(mld_pkg::ST_NOT_MPEG1, mld_pkg::ST_RATE_MISM));
    write_mode((code == mld_pkg::ST_RATE_MISM) ? 1'b1 : 1'($urandom_range(0, 1)));
    r  = allowed_rate();
    b1 = {4'hF, 1'b1, 2'b11, 1'($urandom_range(0, 1))};
    b2 = {4'hC, r, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
    b3 = {2'($urandom_range(0, 2)), 6'($urandom_range(0, 63))};
    case (code)
      mld_pkg::ST_NOT_MPEG1: b1 = {4'hF, 1'b0, 3'($urandom_range(0, 7))};
      mld_pkg::ST_NOT_L1: begin
        b1 = {4'hF, 1'b1, 2'($urandom_range(0, 2)), 1'($urandom_range(0, 1))};
      end
      mld_pkg::ST_NOT_384K: begin
        nib = $urandom_range(0, 14);
        if (nib >= 12) nib++;
        b2[7:4] = 4'(nib);
      end
      mld_pkg::ST_MONO:     b3[7:6] = 2'b11;
      mld_pkg::ST_BAD_RATE: b2[3:2] = mld_pkg::RATE_BAD;
      default: begin
        while (r == sh_lock) r = 2'($urandom_range(0, 2));
        b2[3:2] = r;
      end
    endcase
    send_byte(8'hFF);
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
    send_body(12);
    send_eos();
    send_body(3);
    send_eos();
  endtask

  // Receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: byte=%02h data=%b end=%b status=%0d frames=%0d last=%b",
                   out_data.out_byte, out_data.is_data, out_data.frame_end,
                   out_data.status, out_data.frames_done, out_data.last);
      end else begin
        want_res = pending_q.pop_front();
        if (out_data.out_byte !== want_res.out_byte ||
            out_data.is_data !== want_res.is_data ||
            out_data.frame_end !== want_res.frame_end ||
            out_data.status !== want_res.status ||
            out_data.frames_done !== want_res.frames_done ||
            out_data.last !== want_res.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch exp: byte=%02h data=%b end=%b status=%0d frames=%0d last=%b",
                     want_res.out_byte, want_res.is_data, want_res.frame_end,
                     want_res.status, want_res.frames_done, want_res.last);
            $display("         got: byte=%02h data=%b end=%b status=%0d frames=%0d last=%b",
                     out_data.out_byte, out_data.is_data, out_data.frame_end,
                     out_data.status, out_data.frames_done, out_data.last);
          end
        end
      end
    end
  end

  // Test sequence
  initial begin
    int guard;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    hold_req       = 0;
    hold_left      = 0;
    mismatch_count = 0;
    missing_count  = 0;
    send_idle_pct  = 11;
    recv_idle_pct  = 77;
    shadow_reset();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_mode(1'b0);
    test_hunt_directed();
    test_plain_frames();

    send_idle_pct = 77;
    recv_idle_pct = 11;
    test_mpp_frames();
    test_random_stream(5);
    write_mode(1'b0);
    test_random_stream(3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    write_mode(1'b1);
    test_random_stream(5);
    test_latched_error();

    // Let the last results out, then allow for the block's latency
    in_valid = 1'b0;
    guard = 0;
    while (pending_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    missing_count = pending_q.size();
    if (missing_count != 0) $display("%0d results never arrived", missing_count);
    if (mismatch_count == 0 && missing_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mld_pkg.sv
src/mld_core.sv
src/mld_burst.sv
src/mpeg1_layer1_frame_deframer_top.sv
tb/mpeg1_layer1_frame_deframer_top_test.sv
